// ----- rtl/core/pfbs_pkg.sv -----
// Package for the priority failover backoff selector: widths, register and
// action codes, payload structs and the table entry layout.
// No dependencies.
`timescale 1ns / 1ps

package pfbs_pkg;

  localparam int ENDPOINTS  = 16;
  localparam int IDX_W      = $clog2(ENDPOINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int TIME_BITS  = 32;
  localparam int TALLY_W    = 8;
  localparam int BACKOFF_W  = 16;
  localparam int SHIFT_W    = $clog2(BACKOFF_W);
  localparam int WINDOW_W   = 16;
  localparam int THRESH_W   = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0]     ACTIVE_COUNT_RST = CNT_W'(16);
  localparam logic [WINDOW_W-1:0]  ESC_WINDOW_RST   = WINDOW_W'(60);
  localparam logic [BACKOFF_W-1:0] MAX_BACKOFF_RST  = BACKOFF_W'(60);
  localparam logic [THRESH_W-1:0]  ESC_THRESH_RST   = THRESH_W'(5);

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_FAIL    = 2'd1,
    ACT_DISABLE = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_AVAILABLE   = 2'd0,
    MODE_TEMP_FAILED = 2'd1,
    MODE_DISABLED    = 2'd2
  } mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ACTIVE_COUNT  = 2'd0,
    REG_ESC_WINDOW    = 2'd1,
    REG_MAX_BACKOFF   = 2'd2,
    REG_ESC_THRESHOLD = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MODIFY,
    ST_COMMIT,
    ST_SWEEP,
    ST_SCAN
  } state_t;

  typedef struct packed {
    action_t           action;
    logic [IDX_W-1:0]  endpoint_index;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  next_index;
    logic              next_valid;
  } result_t;

  typedef struct packed {
    mode_t                 mode;
    logic [TALLY_W-1:0]    tally;
    logic [TIME_BITS-1:0]  last_fail;
    logic [TIME_BITS-1:0]  retry_at;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    mode:      MODE_AVAILABLE,
    tally:     '0,
    last_fail: '0,
    retry_at:  '0
  };

endpackage

// ----- rtl/core/priority_failover_backoff_selector_core.sv -----
// Top level of the priority failover backoff selector: endpoint table in a
// synchronous memory, update sequencer and first-usable scan.
// Depends on pfbs_pkg.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; busy then stays high
// until the result is ready, and the result shows on result for exactly one
// cycle with done high, the first cycle busy is low again. The receiver cannot
// hold results off. All endpoint state sits in one 16-entry table with a
// registered read port, so every command ends with a scan that reads one entry
// per cycle from entry 0 and stops at the first usable entry, or after the
// first min(active_count,16) entries when none is usable. Before the scan a
// tick adds nothing; for an endpoint below the active count a disable adds a
// read and a write back, a failure report a read, a count update and a backoff
// with write back, and a reset of temporary failures a sweep of all entries,
// one entry read per cycle, write back one behind. After reset the table is
// ready at once. Configuration writes are taken at any cycle and must come
// only while idle.
module priority_failover_backoff_selector_core
  import pfbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  cmd_t                   cmd,
  output logic                   done,
  output result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  state_t state, state_next;

  logic [CNT_W-1:0]     active_count;
  logic [WINDOW_W-1:0]  esc_window;
  logic [BACKOFF_W-1:0] max_backoff;
  logic [THRESH_W-1:0]  esc_threshold;

  logic [TIME_BITS-1:0] time_now;

  entry_t               mem [ENDPOINTS];
  logic [ENDPOINTS-1:0] vld;
  entry_t               rd_q;
  logic                 vld_q;
  logic [IDX_W-1:0]     addr_q;
  entry_t               ent;

  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  entry_t               mem_wd;

  action_t              act_q;
  logic [IDX_W-1:0]     idx_q;
  logic [CNT_W-1:0]     ptr;
  logic                 pipe;
  logic [TALLY_W-1:0]   tally_q;

  logic                 accept;
  logic [CNT_W-1:0]     limit;
  logic                 in_range;
  logic                 usable;
  logic                 finish;
  logic                 hit;

  // failure report arithmetic
  logic [TIME_BITS-1:0] elapsed;
  logic                 restart;
  logic [TALLY_W-1:0]   tally_base;
  logic [TALLY_W-1:0]   tally_inc;
  logic [TALLY_W-1:0]   shift_amt;
  logic [BACKOFF_W-1:0] pow2;
  logic [BACKOFF_W-1:0] backoff;
  logic [TIME_BITS:0]   retry_sum;
  entry_t               commit_entry;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign limit    = (active_count > CNT_W'(ENDPOINTS)) ? CNT_W'(ENDPOINTS) : active_count;
  assign in_range = ({1'b0, cmd.endpoint_index} < limit);

  // unwritten entries read as their reset contents
  assign ent = vld_q ? rd_q : ENTRY_RESET;

  assign usable = (ent.mode == MODE_AVAILABLE) ||
                  ((ent.mode == MODE_TEMP_FAILED) && (time_now >= ent.retry_at));

  assign elapsed    = time_now - ent.last_fail;
  assign restart    = (ent.tally != '0) &&
                      (elapsed > {{(TIME_BITS-WINDOW_W){1'b0}}, esc_window});
  assign tally_base = restart ? '0 : ent.tally;
  assign tally_inc  = (tally_base == '1) ? tally_base : tally_base + TALLY_W'(1);

  assign shift_amt  = tally_q - TALLY_W'(1);
  assign pow2       = {{(BACKOFF_W-1){1'b0}}, 1'b1} << shift_amt[SHIFT_W-1:0];
  assign backoff    = (shift_amt >= TALLY_W'(BACKOFF_W)) ? max_backoff :
                      (pow2 > max_backoff) ? max_backoff : pow2;
  assign retry_sum  = {1'b0, time_now} + {{(TIME_BITS+1-BACKOFF_W){1'b0}}, backoff};

  always_comb begin
    commit_entry.mode      = (tally_q >= esc_threshold) ? MODE_DISABLED : MODE_TEMP_FAILED;
    commit_entry.tally     = tally_q;
    commit_entry.last_fail = time_now;
    // saturate at the top of the time range
    commit_entry.retry_at  = retry_sum[TIME_BITS] ? '1 : retry_sum[TIME_BITS-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd.action)
            ACT_TICK:    state_next = ST_SCAN;
            ACT_FAIL,
            ACT_DISABLE: state_next = in_range ? ST_FETCH : ST_SCAN;
            ACT_CLEAR:   state_next = ST_SWEEP;
            default:     state_next = ST_SCAN;
          endcase
        end
      end
      ST_FETCH:  state_next = ST_MODIFY;
      ST_MODIFY: state_next = (act_q == ACT_FAIL) ? ST_COMMIT : ST_SCAN;
      ST_COMMIT: state_next = ST_SCAN;
      ST_SWEEP:  state_next = ptr[IDX_W] ? ST_SCAN : ST_SWEEP;
      ST_SCAN:   state_next = finish ? ST_IDLE : ST_SCAN;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory controls and scan outcome
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = idx_q;
    mem_wd  = ent;
    rd_addr = ptr[IDX_W-1:0];
    finish  = 1'b0;
    hit     = 1'b0;
    case (state)
      ST_MODIFY: begin
        if (act_q == ACT_DISABLE) begin
          mem_we      = 1'b1;
          mem_wd.mode = MODE_DISABLED;
        end
      end
      ST_COMMIT: begin
        mem_we = 1'b1;
        mem_wd = commit_entry;
      end
      ST_SWEEP: begin
        // write back one entry behind the read
        if (pipe && (ent.mode == MODE_TEMP_FAILED)) begin
          mem_we          = 1'b1;
          mem_wa          = addr_q;
          mem_wd.mode     = MODE_AVAILABLE;
          mem_wd.tally    = '0;
          mem_wd.retry_at = '0;
        end
      end
      ST_SCAN: begin
        if (pipe && usable) begin
          finish = 1'b1;
          hit    = 1'b1;
        end else if (ptr >= limit) begin
          finish = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count  <= ACTIVE_COUNT_RST;
      esc_window    <= ESC_WINDOW_RST;
      max_backoff   <= MAX_BACKOFF_RST;
      esc_threshold <= ESC_THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_ACTIVE_COUNT:  active_count  <= cfg_wdata[CNT_W-1:0];
        REG_ESC_WINDOW:    esc_window    <= cfg_wdata[WINDOW_W-1:0];
        REG_MAX_BACKOFF:   max_backoff   <= cfg_wdata[BACKOFF_W-1:0];
        REG_ESC_THRESHOLD: esc_threshold <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // time counter holds at all ones
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
    end else if (accept && (cmd.action == ACT_TICK) && (time_now != '1)) begin
      time_now <= time_now + TIME_BITS'(1);
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q   <= mem[rd_addr];
    addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[mem_wa] <= 1'b1;
      end
      vld_q <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q <= cmd.action;
      idx_q <= cmd.endpoint_index;
    end
    if (state == ST_MODIFY) begin
      tally_q <= tally_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      pipe <= 1'b0;
    end else if ((state_next == ST_SCAN) && (state != ST_SCAN)) begin
      ptr  <= '0;
      pipe <= 1'b0;
    end else if (state == ST_IDLE) begin
      ptr  <= (state_next == ST_FETCH) ? {1'b0, cmd.endpoint_index} : '0;
      pipe <= 1'b0;
    end else if (state == ST_SWEEP) begin
      ptr  <= ptr[IDX_W] ? ptr : ptr + CNT_W'(1);
      pipe <= !ptr[IDX_W];
    end else if (state == ST_SCAN) begin
      ptr  <= (ptr < limit) ? ptr + CNT_W'(1) : ptr;
      pipe <= (ptr < limit);
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.next_index <= hit ? addr_q : '0;
      result.next_valid <= hit;
    end
  end

endmodule

// ----- rtl/core/pfbs_chk.sv -----
// Port-level checker for the priority failover backoff selector, and the
// bind that attaches it to the top level. Depends on pfbs_pkg.
`timescale 1ns / 1ps

module pfbs_chk
  import pfbs_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input cmd_t    cmd,
  input logic    done,
  input result_t result
);

  // a taken command always raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after command");

  // busy drops exactly when the result beat appears
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result beat");

  a_done_fall: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $fell(busy))
    else $error("result beat without end of busy");

  // no usable endpoint reports index zero
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.next_valid) |-> (result.next_index == '0))
    else $error("invalid result with nonzero index");

  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result beats in a row");

endmodule

bind priority_failover_backoff_selector_core pfbs_chk u_pfbs_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cmd    (cmd),
  .done   (done),
  .result (result)
);
